>>> hdl/gcds_pkg.sv
// Package with the widths, codes and reset values of the greedy coin dispense sequencer.
package gcds_pkg;

  localparam int NUM_PUSHERS = 4;
  localparam int SEQ_DEPTH   = 16;

  localparam int COIN_TYPES  = 4;
  localparam int TYPE_W      = 2;
  localparam int TCNT_W      = 3;
  localparam int MAX_TYPES   = (NUM_PUSHERS < COIN_TYPES) ? NUM_PUSHERS : COIN_TYPES;

  localparam int AMT_W       = 15;
  localparam int STEP_W      = $clog2(AMT_W);
  localparam int CNT_W       = $clog2(SEQ_DEPTH);
  localparam int LEN_W       = $clog2(SEQ_DEPTH) + 1;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [AMT_W-1:0]  COIN_0_RST = AMT_W'(200);
  localparam logic [AMT_W-1:0]  COIN_1_RST = AMT_W'(100);
  localparam logic [AMT_W-1:0]  COIN_2_RST = AMT_W'(50);
  localparam logic [AMT_W-1:0]  COIN_3_RST = AMT_W'(20);
  localparam logic [TCNT_W-1:0] NTYPES_RST = TCNT_W'(4);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_COIN_0 = 3'd0,
    CFG_COIN_1 = 3'd1,
    CFG_COIN_2 = 3'd2,
    CFG_COIN_3 = 3'd3,
    CFG_NTYPES = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_CHECK
  } state_t;

endpackage

>>> hdl/greedy_coin_dispense_sequencer.sv
// Top level of the greedy coin dispense sequencer: planner, bit-serial divider and push walker.
// Every accepted transaction yields exactly one result transaction. While a plan is active the
// result is registered in the cycle after acceptance. While idle the amount is split over the coin
// types in register order by a restoring divider that retires one quotient bit per cycle; each
// non-zero coin type visited passes through setup, 15 divide steps and a length check, a zero
// one through setup alone; the split stops once nothing is left, every coin type in use is
// visited or the plan grows too long. A new transaction is taken only while no plan is being
// built and the output register is empty or is emptied in the same cycle.
module greedy_coin_dispense_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gcds_pkg::IN_W-1:0]        in_tdata,   // amount[14:0], pusher_done[15]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gcds_pkg::OUT_W-1:0]       out_tdata,  // push_valid[0], push_index[2:1],
                                                       // ready_res[3], zero[7:4]
  input  logic                             cfg_we,
  input  logic [gcds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [gcds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  gcds_pkg::state_t state_r, state_nxt;

  logic [gcds_pkg::AMT_W-1:0]  coin_r   [gcds_pkg::COIN_TYPES];
  logic [gcds_pkg::AMT_W-1:0]  coin_nxt [gcds_pkg::COIN_TYPES];
  logic [gcds_pkg::TCNT_W-1:0] ntypes_r, ntypes_nxt;

  logic [gcds_pkg::AMT_W-1:0]  rem_r, rem_nxt;
  logic [gcds_pkg::AMT_W-1:0]  dvd_r, dvd_nxt;
  logic [gcds_pkg::AMT_W-1:0]  part_r, part_nxt;
  logic [gcds_pkg::AMT_W-1:0]  div_r, div_nxt;
  logic [gcds_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [gcds_pkg::TCNT_W-1:0] t_r, t_nxt;
  logic [gcds_pkg::LEN_W-1:0]  len_r, len_nxt;

  logic [gcds_pkg::CNT_W-1:0]  cnt_r   [gcds_pkg::COIN_TYPES];
  logic [gcds_pkg::CNT_W-1:0]  cnt_nxt [gcds_pkg::COIN_TYPES];
  logic                        busy_r, busy_nxt;
  logic [gcds_pkg::TYPE_W-1:0] cur_r, cur_nxt;
  logic [gcds_pkg::CNT_W-1:0]  left_r, left_nxt;

  logic                        out_tvalid_r, out_tvalid_nxt;
  logic                        out_push_r, out_push_nxt;
  logic [gcds_pkg::TYPE_W-1:0] out_idx_r, out_idx_nxt;
  logic                        out_rdy_r, out_rdy_nxt;

  logic                        in_fire;
  logic [gcds_pkg::AMT_W-1:0]  in_amount;
  logic                        in_done;
  logic [gcds_pkg::TCNT_W-1:0] types;
  logic                        setup_end;
  logic                        coin_zero;
  logic [gcds_pkg::AMT_W:0]    trial;
  logic [gcds_pkg::AMT_W:0]    diff;
  logic                        ge;
  logic [gcds_pkg::AMT_W:0]    sum;
  logic                        chk_fail;
  logic [gcds_pkg::TYPE_W-1:0] first_idx;
  logic                        first_found;
  logic [gcds_pkg::TYPE_W-1:0] next_idx;
  logic                        next_found;

  assign in_amount = in_tdata[gcds_pkg::AMT_W-1:0];
  assign in_done   = in_tdata[gcds_pkg::AMT_W];
  assign in_tready = (state_r == gcds_pkg::ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(gcds_pkg::OUT_W - gcds_pkg::TYPE_W - 2)'(0), out_rdy_r, out_idx_r,
                       out_push_r};

  assign types = (ntypes_r > gcds_pkg::TCNT_W'(gcds_pkg::MAX_TYPES)) ?
                 gcds_pkg::TCNT_W'(gcds_pkg::MAX_TYPES) : ntypes_r;

  assign setup_end = (t_r >= types) || (rem_r == '0);
  assign coin_zero = (coin_r[t_r[gcds_pkg::TYPE_W-1:0]] == '0);

  assign trial = {part_r, dvd_r[gcds_pkg::AMT_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  assign sum      = {1'b0, dvd_r} + (gcds_pkg::AMT_W + 1)'(len_r);
  assign chk_fail = (sum >= (gcds_pkg::AMT_W + 1)'(gcds_pkg::SEQ_DEPTH));

  always_comb begin
    first_idx   = '0;
    first_found = 1'b0;
    next_idx    = '0;
    next_found  = 1'b0;
    for (int i = gcds_pkg::COIN_TYPES - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        first_idx   = gcds_pkg::TYPE_W'(i);
        first_found = 1'b1;
      end
      if ((cnt_r[i] != '0) && (gcds_pkg::TYPE_W'(i) > cur_r)) begin
        next_idx   = gcds_pkg::TYPE_W'(i);
        next_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcds_pkg::ST_IDLE: begin
        if (in_fire && !busy_r) begin
          state_nxt = gcds_pkg::ST_SETUP;
        end
      end
      gcds_pkg::ST_SETUP: begin
        if (setup_end) begin
          state_nxt = gcds_pkg::ST_IDLE;
        end else if (!coin_zero) begin
          state_nxt = gcds_pkg::ST_DIV;
        end
      end
      gcds_pkg::ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = gcds_pkg::ST_CHECK;
        end
      end
      gcds_pkg::ST_CHECK: begin
        state_nxt = chk_fail ? gcds_pkg::ST_IDLE : gcds_pkg::ST_SETUP;
      end
      default: begin
        state_nxt = gcds_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    coin_nxt       = coin_r;
    ntypes_nxt     = ntypes_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    part_nxt       = part_r;
    div_nxt        = div_r;
    step_nxt       = step_r;
    t_nxt          = t_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    busy_nxt       = busy_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_push_nxt   = out_push_r;
    out_idx_nxt    = out_idx_r;
    out_rdy_nxt    = out_rdy_r;

    if (cfg_we) begin
      case (cfg_addr)
        gcds_pkg::CFG_COIN_0: coin_nxt[0] = cfg_wdata[gcds_pkg::AMT_W-1:0];
        gcds_pkg::CFG_COIN_1: coin_nxt[1] = cfg_wdata[gcds_pkg::AMT_W-1:0];
        gcds_pkg::CFG_COIN_2: coin_nxt[2] = cfg_wdata[gcds_pkg::AMT_W-1:0];
        gcds_pkg::CFG_COIN_3: coin_nxt[3] = cfg_wdata[gcds_pkg::AMT_W-1:0];
        gcds_pkg::CFG_NTYPES: ntypes_nxt  = cfg_wdata[gcds_pkg::TCNT_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      gcds_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (busy_r) begin
            if (in_done) begin
              if (left_r == gcds_pkg::CNT_W'(1)) begin
                if (next_found) begin
                  cur_nxt  = next_idx;
                  left_nxt = cnt_r[next_idx];
                end else begin
                  busy_nxt = 1'b0;
                end
              end else begin
                left_nxt = left_r - gcds_pkg::CNT_W'(1);
              end
            end
            out_tvalid_nxt = 1'b1;
            out_push_nxt   = 1'b1;
            out_idx_nxt    = cur_r;
            out_rdy_nxt    = !busy_nxt;
          end else begin
            rem_nxt = in_amount;
            t_nxt   = '0;
            len_nxt = '0;
            for (int i = 0; i < gcds_pkg::COIN_TYPES; i++) begin
              cnt_nxt[i] = '0;
            end
          end
        end
      end
      gcds_pkg::ST_SETUP: begin
        if (setup_end) begin
          out_tvalid_nxt = 1'b1;
          if ((rem_r == '0) && (len_r != '0) && first_found) begin
            busy_nxt     = 1'b1;
            cur_nxt      = first_idx;
            left_nxt     = cnt_r[first_idx];
            out_push_nxt = 1'b1;
            out_idx_nxt  = first_idx;
            out_rdy_nxt  = 1'b0;
          end else begin
            out_push_nxt = 1'b0;
            out_idx_nxt  = '0;
            out_rdy_nxt  = 1'b1;
          end
        end else if (coin_zero) begin
          t_nxt = t_r + gcds_pkg::TCNT_W'(1);
        end else begin
          div_nxt  = coin_r[t_r[gcds_pkg::TYPE_W-1:0]];
          dvd_nxt  = rem_r;
          part_nxt = '0;
          step_nxt = gcds_pkg::STEP_W'(gcds_pkg::AMT_W - 1);
        end
      end
      gcds_pkg::ST_DIV: begin
        part_nxt = ge ? diff[gcds_pkg::AMT_W-1:0] : trial[gcds_pkg::AMT_W-1:0];
        dvd_nxt  = {dvd_r[gcds_pkg::AMT_W-2:0], ge};
        step_nxt = step_r - gcds_pkg::STEP_W'(1);
      end
      gcds_pkg::ST_CHECK: begin
        if (chk_fail) begin
          out_tvalid_nxt = 1'b1;
          out_push_nxt   = 1'b0;
          out_idx_nxt    = '0;
          out_rdy_nxt    = 1'b1;
        end else begin
          cnt_nxt[t_r[gcds_pkg::TYPE_W-1:0]] = dvd_r[gcds_pkg::CNT_W-1:0];
          len_nxt = sum[gcds_pkg::LEN_W-1:0];
          rem_nxt = part_r;
          t_nxt   = t_r + gcds_pkg::TCNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gcds_pkg::ST_IDLE;
      coin_r[0]    <= gcds_pkg::COIN_0_RST;
      coin_r[1]    <= gcds_pkg::COIN_1_RST;
      coin_r[2]    <= gcds_pkg::COIN_2_RST;
      coin_r[3]    <= gcds_pkg::COIN_3_RST;
      ntypes_r     <= gcds_pkg::NTYPES_RST;
      len_r        <= '0;
      for (int i = 0; i < gcds_pkg::COIN_TYPES; i++) begin
        cnt_r[i] <= '0;
      end
      busy_r       <= 1'b0;
      cur_r        <= '0;
      left_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      coin_r       <= coin_nxt;
      ntypes_r     <= ntypes_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
      busy_r       <= busy_nxt;
      cur_r        <= cur_nxt;
      left_r       <= left_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    part_r     <= part_nxt;
    div_r      <= div_nxt;
    step_r     <= step_nxt;
    t_r        <= t_nxt;
    out_push_r <= out_push_nxt;
    out_idx_r  <= out_idx_nxt;
    out_rdy_r  <= out_rdy_nxt;
  end

  a_busy_has_coins: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != '0) && (left_r <= cnt_r[cur_r]))
    else $error("active plan has no coin left for the current pusher");

  a_plan_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gcds_pkg::ST_IDLE) |-> !busy_r)
    else $error("planning started while a plan is active");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < gcds_pkg::LEN_W'(gcds_pkg::SEQ_DEPTH))
    else $error("plan length reached the sequence depth");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_push_r) |-> out_rdy_r)
    else $error("result without a push does not report idle");

  a_busy_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |=> (out_tvalid_r && out_push_r && (out_idx_r == $past(cur_r))))
    else $error("transaction during an active plan gave no push of the current pusher");

endmodule

>>> test/greedy_coin_dispense_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the greedy coin dispense sequencer with a predicting scoreboard.
module greedy_coin_dispense_sequencer_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;
  localparam int NUM_PHASES = 8;
  localparam logic [gcds_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic                        ready_res;
    logic [gcds_pkg::TYPE_W-1:0] push_index;
    logic                        push_valid;
  } push_cmd_t;

  class coin_plan_predictor;
    logic [gcds_pkg::AMT_W-1:0]  coin_value[gcds_pkg::COIN_TYPES];
    logic [gcds_pkg::TCNT_W-1:0] type_count;
    bit                          busy;
    logic [gcds_pkg::TYPE_W-1:0] plan[gcds_pkg::SEQ_DEPTH];
    int unsigned                 plan_len;
    int unsigned                 plan_pos;
    push_cmd_t                   expected_pushes[$];
    int                          mismatches;

    function new();
      coin_value[0] = gcds_pkg::COIN_0_RST;
      coin_value[1] = gcds_pkg::COIN_1_RST;
      coin_value[2] = gcds_pkg::COIN_2_RST;
      coin_value[3] = gcds_pkg::COIN_3_RST;
      type_count = gcds_pkg::NTYPES_RST;
      busy = 1'b0;
      plan_len = 0;
      plan_pos = 0;
      mismatches = 0;
    endfunction

    function int unsigned types_in_use();
      return (type_count > gcds_pkg::MAX_TYPES) ? gcds_pkg::MAX_TYPES : type_count;
    endfunction

    function void write_reg(logic [gcds_pkg::CFG_ADDR_W-1:0] idx,
                            logic [gcds_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gcds_pkg::CFG_COIN_0, gcds_pkg::CFG_COIN_1, gcds_pkg::CFG_COIN_2,
        gcds_pkg::CFG_COIN_3: begin
          coin_value[idx[gcds_pkg::TYPE_W-1:0]] = data[gcds_pkg::AMT_W-1:0];
        end
        gcds_pkg::CFG_NTYPES: type_count = data[gcds_pkg::TCNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void build_plan(logic [gcds_pkg::AMT_W-1:0] amount);
      int unsigned rem;
      int unsigned len;
      int unsigned cnt;
      int unsigned v;
      plan_len = 0;
      rem = amount;
      len = 0;
      for (int t = 0; t < types_in_use() && rem != 0; t++) begin
        v = coin_value[t];
        if (v == 0) continue;
        cnt = rem / v;
        if (len + cnt >= gcds_pkg::SEQ_DEPTH) return;
        for (int k = 0; k < cnt; k++) begin
          plan[len] = gcds_pkg::TYPE_W'(t);
          len++;
        end
        rem -= cnt * v;
      end
      if (rem != 0) return;
      plan_len = len;
    endfunction

    function void note_amount(logic [gcds_pkg::AMT_W-1:0] amount, logic done);
      push_cmd_t res;
      res = '0;
      if (!busy) begin
        build_plan(amount);
        plan_pos = 0;
        if (plan_len != 0) begin
          res.push_valid = 1'b1;
          res.push_index = plan[0];
          busy = 1'b1;
        end
      end else if (plan_pos >= plan_len) begin
        busy = 1'b0;
      end else begin
        res.push_valid = 1'b1;
        res.push_index = plan[plan_pos];
        if (done) begin
          plan_pos++;
          if (plan_pos >= plan_len) busy = 1'b0;
        end
      end
      res.ready_res = !busy;
      expected_pushes.push_back(res);
    endfunction

    function void check_push(logic [gcds_pkg::OUT_W-1:0] data);
      push_cmd_t want;
      if (expected_pushes.size() == 0) begin
        $error("result with nothing expected: %h", data);
        mismatches++;
        return;
      end
      want = expected_pushes.pop_front();
      if (data[0] !== want.push_valid) begin
        $error("push_valid: expected %0d, actual %0d", want.push_valid, data[0]);
        mismatches++;
      end
      if (data[2:1] !== want.push_index) begin
        $error("push_index: expected %0d, actual %0d", want.push_index, data[2:1]);
        mismatches++;
      end
      if (data[3] !== want.ready_res) begin
        $error("ready_res: expected %0d, actual %0d", want.ready_res, data[3]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pushes.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gcds_pkg::IN_W-1:0]       in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [gcds_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_we = 1'b0;
  logic [gcds_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [gcds_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  coin_plan_predictor tracker;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  int phase_items[NUM_PHASES] = '{200, 250, 250, 250, 80, 250, 250, 250};

  greedy_coin_dispense_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // amount[14:0], pusher_done[15]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // push_valid[0], push_index[2:1], ready_res[3], zero[7:4]
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_push(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [gcds_pkg::AMT_W-1:0] amt, input logic done);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {done, amt};
    do @(posedge clk); while (!in_tready);
    tracker.note_amount(amt, done);
    @(negedge clk);
  endtask

  task automatic walk_plan(input int every);
    int k;
    k = 0;
    while (tracker.busy) begin
      send_item(gcds_pkg::AMT_W'($urandom), (k % every) == every - 1);
      k++;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gcds_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [gcds_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure_phase(input int ph);
    case (ph)
      1: begin
        write_reg(gcds_pkg::CFG_COIN_0, 15'd32767);
        write_reg(gcds_pkg::CFG_COIN_1, 15'd1);
        write_reg(gcds_pkg::CFG_COIN_2, 15'd1);
        write_reg(gcds_pkg::CFG_COIN_3, 15'd1);
        write_reg(gcds_pkg::CFG_NTYPES, 15'd4);
      end
      2: begin
        write_reg(gcds_pkg::CFG_COIN_0, 15'd1000);
        write_reg(gcds_pkg::CFG_COIN_1, 15'd300);
        write_reg(gcds_pkg::CFG_COIN_2, 15'd7);
        write_reg(gcds_pkg::CFG_COIN_3, 15'd1);
      end
      3: begin
        write_reg(gcds_pkg::CFG_COIN_0, 15'd0);
        write_reg(gcds_pkg::CFG_COIN_1, 15'd50);
        write_reg(gcds_pkg::CFG_COIN_2, 15'd10);
        write_reg(gcds_pkg::CFG_NTYPES, 15'd7);
      end
      4: begin
        write_reg(gcds_pkg::CFG_NTYPES, 15'd0);
        write_reg(CFG_UNUSED_IDX, 15'h7FFF);
      end
      5: begin
        write_reg(gcds_pkg::CFG_COIN_0, 15'd64);
        write_reg(gcds_pkg::CFG_COIN_1, 15'd32);
        write_reg(gcds_pkg::CFG_COIN_2, 15'd16);
        write_reg(gcds_pkg::CFG_COIN_3, 15'd8);
        write_reg(gcds_pkg::CFG_NTYPES, 15'd2);
      end
      6: begin
        write_reg(gcds_pkg::CFG_COIN_0, 15'd5);
        write_reg(gcds_pkg::CFG_COIN_1, 15'd3);
        write_reg(gcds_pkg::CFG_COIN_2, 15'd2);
        write_reg(gcds_pkg::CFG_COIN_3, 15'd1);
        write_reg(gcds_pkg::CFG_NTYPES, 15'd5);
      end
      default: begin
        write_reg(gcds_pkg::CFG_COIN_0, gcds_pkg::CFG_DATA_W'($urandom_range(1, 2000)));
        write_reg(gcds_pkg::CFG_COIN_1, gcds_pkg::CFG_DATA_W'($urandom_range(1, 500)));
        write_reg(gcds_pkg::CFG_COIN_2, gcds_pkg::CFG_DATA_W'($urandom_range(1, 100)));
        write_reg(gcds_pkg::CFG_COIN_3, gcds_pkg::CFG_DATA_W'($urandom_range(1, 20)));
        write_reg(gcds_pkg::CFG_NTYPES, gcds_pkg::CFG_DATA_W'($urandom_range(1, 4)));
      end
    endcase
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly sums of a random handful of the coins in use, so that plans are usually built.
  function automatic logic [gcds_pkg::AMT_W-1:0] pick_amount();
    int unsigned left;
    int unsigned cnt;
    int unsigned sum;
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return gcds_pkg::AMT_W'($urandom);
    if (r < 15) return '0;
    left = $urandom_range(1, gcds_pkg::SEQ_DEPTH + 1);
    sum = 0;
    for (int t = 0; t < tracker.types_in_use(); t++) begin
      cnt = $urandom_range(0, left);
      left -= cnt;
      sum += cnt * tracker.coin_value[t];
    end
    if (r < 22) sum += 1;
    if (sum == 0 || sum > 32767) return gcds_pkg::AMT_W'($urandom);
    return gcds_pkg::AMT_W'(sum);
  endfunction

  task automatic run_random(input int count);
    logic [gcds_pkg::AMT_W-1:0] amt;
    logic done;
    for (int i = 0; i < count; i++) begin
      done = ($urandom_range(0, 99) < 35);
      if (tracker.busy) amt = gcds_pkg::AMT_W'($urandom);
      else amt = pick_amount();
      send_item(amt, done);
    end
  endtask

  initial begin
    tracker = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(15'd0, 1'b1);
    send_item(15'd30, 1'b1);
    send_item(15'h7FFF, 1'b1);
    send_item(15'd3200, 1'b0);
    // One coin of each type; the done flag on the opening push must not advance the plan.
    send_item(15'd370, 1'b1);
    walk_plan(2);
    send_item(15'd3000, 1'b0);
    walk_plan(1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        configure_phase(ph);
      end
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      run_random(phase_items[ph]);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/gcds_pkg.sv
hdl/greedy_coin_dispense_sequencer.sv
test/greedy_coin_dispense_sequencer_tb.sv
